/* hw/rtl/dsr_pkg.sv */
// Shared types and constants for the DMX slot receiver.
package dsr_pkg;

   // Channel window size and frame length, in slots.
   localparam logic [7:0] CHANNELS    = 8'd16;
   localparam logic [7:0] FRAME_SLOTS = 8'd128;

   // Base address is always a multiple of four.
   localparam logic [6:0] BASE_MASK = 7'b1111100;

   // Configuration register reset values.
   localparam logic [6:0]  BASE_RESET    = 7'd0;
   localparam logic [15:0] DATA_RESET    = 16'd100;
   localparam logic [15:0] SIGNAL_RESET  = 16'd1000;
   localparam logic [15:0] FRAMING_RESET = 16'd1000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BASE_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_DATA_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_SIGNAL_TIMEOUT = 2'd2;
   localparam logic [1:0] CSR_FRAMING_HOLD   = 2'd3;

   // Request opcodes.
   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_RESYNC = 2'd2;

   // Per-transaction controls for the watchdog block.
   typedef struct packed {
      logic tick;
      logic byte_seen;
      logic frame_err;
      logic data_hit;
   } wdog_ctl_type;

   typedef struct packed {
      logic data_valid;
      logic no_signal;
      logic framing_fault;
   } flags_type;

endpackage

/* hw/rtl/dsr_if.sv */
// Request and response channel interfaces for the DMX slot receiver.
interface dsr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       framing_error;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output framing_error, output rx_byte,
                   input ready);
   modport sink (input valid, input opcode, input framing_error, input rx_byte,
                 output ready);
endinterface

interface dsr_rsp_if;
   logic       valid;
   logic       ready;
   logic       channel_write;
   logic [6:0] channel_index;
   logic [7:0] channel_level;
   logic       data_valid_flag;
   logic       no_signal_flag;
   logic       framing_fault_flag;

   modport source (output valid, output channel_write, output channel_index,
                   output channel_level, output data_valid_flag, output no_signal_flag,
                   output framing_fault_flag, input ready);
   modport sink (input valid, input channel_write, input channel_index,
                 input channel_level, input data_valid_flag, input no_signal_flag,
                 input framing_fault_flag, output ready);
endinterface

/* hw/rtl/dsr_watchdog.sv */
// Data, signal and framing watchdog timers with their indicator flags.
module dsr_watchdog (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dsr_pkg::wdog_ctl_type ctl,
   input  logic [15:0]           data_timeout,
   input  logic [15:0]           signal_timeout,
   input  logic [15:0]           framing_hold,
   output dsr_pkg::flags_type    flags_next
);

   logic [15:0]        data_timer_ff, data_timer_in;
   logic [15:0]        signal_timer_ff, signal_timer_in;
   logic [15:0]        framing_timer_ff, framing_timer_in;
   dsr_pkg::flags_type flags_ff, flags_in;

   always_comb begin
      data_timer_in    = data_timer_ff;
      signal_timer_in  = signal_timer_ff;
      framing_timer_in = framing_timer_ff;
      flags_in         = flags_ff;

      if (ctl.tick) begin
         if (data_timer_ff != 16'd0) begin
            data_timer_in       = data_timer_ff - 16'd1;
            flags_in.data_valid = 1'b1;
         end else begin
            flags_in.data_valid = 1'b0;
         end
         if (signal_timer_ff != 16'd0) begin
            signal_timer_in    = signal_timer_ff - 16'd1;
            flags_in.no_signal = 1'b0;
         end else begin
            flags_in.no_signal = 1'b1;
         end
         if (framing_timer_ff != 16'd0) begin
            framing_timer_in = framing_timer_ff - 16'd1;
         end else begin
            flags_in.framing_fault = 1'b0;
         end
      end

      if (ctl.byte_seen) begin
         signal_timer_in = signal_timeout;
      end
      if (ctl.frame_err) begin
         framing_timer_in       = framing_hold;
         flags_in.framing_fault = 1'b1;
      end
      if (ctl.data_hit) begin
         data_timer_in = data_timeout;
      end
   end

   assign flags_next = flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_timer_ff    <= '0;
         signal_timer_ff  <= '0;
         framing_timer_ff <= '0;
         flags_ff         <= '0;
      end else if (step) begin
         data_timer_ff    <= data_timer_in;
         signal_timer_ff  <= signal_timer_in;
         framing_timer_ff <= framing_timer_in;
         flags_ff         <= flags_in;
      end
   end

endmodule

/* hw/rtl/dmx_slot_receiver.sv */
// DMX512 slot receiver top level: sync tracking, slot window and result register.
//
//   channel  | dir | transaction
//   ---------+-----+--------------------------------------------------------
//   req_chan | in  | opcode (byte / tick / resync), framing_error, rx_byte
//   rsp_chan | out | channel write, index, level and the three indicator flags
//   csr_*    | in  | write-only register port, one write per cycle
//
// One transaction per cycle sustained while rsp_chan is ready. An input register
// (stage 1) feeds the decode and state update, which load the result register.
// Stage 1 and the result register each hold one transaction, so one more can enter
// stage 1 while a result waits; a stall on rsp_chan backs up into req_chan.ready.
// Synchronous active-high reset clears valids, sync state, slot counter, timers,
// flags and restores the register defaults.
module dmx_slot_receiver (
   input  logic        clock,
   input  logic        reset,
   dsr_req_if.sink     req_chan,
   dsr_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_NOSYNC  = 2'd0,
      ST_WAIT    = 2'd1,
      ST_PAYLOAD = 2'd2
   } sync_type;

   // Configuration registers
   logic [6:0]  base_ff;
   logic [15:0] data_timeout_ff;
   logic [15:0] signal_timeout_ff;
   logic [15:0] framing_hold_ff;

   // Stage 1: accepted transaction
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_opcode_ff;
   logic       s1_ferr_ff;
   logic [7:0] s1_byte_ff;

   // Sync state
   sync_type   sync_ff, sync_in;
   logic [7:0] slot_ff, slot_in;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic               out_write_ff, out_write_in;
   logic [6:0]         out_index_ff, out_index_in;
   logic [7:0]         out_level_ff, out_level_in;
   dsr_pkg::flags_type out_flags_ff, flags_next;

   logic                  req_take;
   logic                  advance;
   logic [6:0]            base;
   logic [8:0]            slot_diff;
   logic                  in_window;
   logic [7:0]            slot_inc;
   dsr_pkg::wdog_ctl_type wdog_ctl;

   // Move stage 1 into the result register when that slot is free or drains now.
   assign advance          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // Channel window: slot - base in [0, CHANNELS)
   assign base      = base_ff & dsr_pkg::BASE_MASK;
   assign slot_diff = {1'b0, slot_ff} - {2'b00, base};
   assign in_window = !slot_diff[8] && (slot_diff[7:0] < dsr_pkg::CHANNELS);
   assign slot_inc  = slot_ff + 8'd1;

   always_comb begin
      sync_in      = sync_ff;
      slot_in      = slot_ff;
      out_write_in = 1'b0;
      out_index_in = '0;
      out_level_in = '0;
      wdog_ctl     = '0;

      case (s1_opcode_ff)
         dsr_pkg::OP_BYTE: begin
            wdog_ctl.byte_seen = 1'b1;
            if (s1_ferr_ff) begin
               // break: syncs an idle receiver, flags a fault otherwise
               if (sync_ff == ST_NOSYNC) begin
                  slot_in = '0;
                  sync_in = ST_WAIT;
               end else begin
                  wdog_ctl.frame_err = 1'b1;
               end
            end else if (sync_ff == ST_WAIT) begin
               if (s1_byte_ff == 8'h00) begin
                  sync_in = ST_PAYLOAD;
               end
            end else if (sync_ff == ST_PAYLOAD) begin
               if (in_window) begin
                  out_write_in      = 1'b1;
                  out_index_in      = slot_diff[6:0];
                  out_level_in      = s1_byte_ff;
                  wdog_ctl.data_hit = (s1_byte_ff != 8'h00);
               end
               slot_in = slot_inc;
               if (slot_inc >= dsr_pkg::FRAME_SLOTS) begin
                  sync_in = ST_NOSYNC;
               end
            end
         end
         dsr_pkg::OP_TICK: begin
            wdog_ctl.tick = 1'b1;
         end
         dsr_pkg::OP_RESYNC: begin
            slot_in = '0;
            sync_in = ST_NOSYNC;
         end
         default: begin
         end
      endcase
   end

   dsr_watchdog u_watchdog (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .ctl            (wdog_ctl),
      .data_timeout   (data_timeout_ff),
      .signal_timeout (signal_timeout_ff),
      .framing_hold   (framing_hold_ff),
      .flags_next     (flags_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff           <= dsr_pkg::BASE_RESET;
         data_timeout_ff   <= dsr_pkg::DATA_RESET;
         signal_timeout_ff <= dsr_pkg::SIGNAL_RESET;
         framing_hold_ff   <= dsr_pkg::FRAMING_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dsr_pkg::CSR_BASE_ADDRESS:   base_ff           <= csr_wdata[6:0];
            dsr_pkg::CSR_DATA_TIMEOUT:   data_timeout_ff   <= csr_wdata;
            dsr_pkg::CSR_SIGNAL_TIMEOUT: signal_timeout_ff <= csr_wdata;
            dsr_pkg::CSR_FRAMING_HOLD:   framing_hold_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sync_ff      <= ST_NOSYNC;
         slot_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            sync_ff <= sync_in;
            slot_ff <= slot_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_chan.opcode;
         s1_ferr_ff   <= req_chan.framing_error;
         s1_byte_ff   <= req_chan.rx_byte;
      end
      if (advance) begin
         out_write_ff <= out_write_in;
         out_index_ff <= out_index_in;
         out_level_ff <= out_level_in;
         out_flags_ff <= flags_next;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.channel_write      = out_write_ff;
   assign rsp_chan.channel_index      = out_index_ff;
   assign rsp_chan.channel_level      = out_level_ff;
   assign rsp_chan.data_valid_flag    = out_flags_ff.data_valid;
   assign rsp_chan.no_signal_flag     = out_flags_ff.no_signal;
   assign rsp_chan.framing_fault_flag = out_flags_ff.framing_fault;

`ifndef SYNTHESIS
   a_index_in_window: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_write_ff |-> {1'b0, out_index_ff} < dsr_pkg::CHANNELS)
      else $error("channel index outside window");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_write_ff |-> out_index_ff == 7'd0 && out_level_ff == 8'd0)
      else $error("index or level nonzero without channel write");

   a_payload_slot_range: assert property (@(posedge clock) disable iff (reset)
      sync_ff == ST_PAYLOAD |-> slot_ff < dsr_pkg::FRAME_SLOTS)
      else $error("slot counter past frame end in payload");

   a_break_syncs: assert property (@(posedge clock) disable iff (reset)
      advance && s1_opcode_ff == dsr_pkg::OP_BYTE && s1_ferr_ff && sync_ff == ST_NOSYNC
      |=> sync_ff == ST_WAIT && slot_ff == 8'd0)
      else $error("break did not start a frame");
`endif

endmodule
